>>> sv/circular_deque_unit_defines.svh
// ----------------------------------------------------------------------------
// circular_deque_unit_defines: assertion macros
// Shared assertion forms for the deque checker. Each macro takes a label, an
// antecedent and a consequent, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");

// Next-cycle implication.
`define CDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

>>> sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque
// Operation codes, sequencer states, field widths and the result record.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned COUNT_W       = 10;
  localparam int unsigned FUNC_W        = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_QUERY      = 3'd4
  } cdq_func_t;

  typedef enum logic {
    CDQ_IDLE,
    CDQ_RESP
  } cdq_state_t;

  typedef struct packed {
    logic                      ends_valid;
    logic signed [WORD_W-1:0]  back_value;
    logic signed [WORD_W-1:0]  front_value;
    logic                      is_empty;
    logic [COUNT_W-1:0]        count;
    logic                      overflow;
    logic                      popped_valid;
    logic signed [WORD_W-1:0]  popped_value;
  } cdq_result_t;

endpackage

>>> sv/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram: ring storage
// Single-port-write, single-port-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
module cdq_ram import cdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic signed [WORD_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic signed [WORD_W-1:0] rdata
);

  logic signed [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read, so a stalled response keeps it.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl: deque sequencer
// Keeps the head and tail pointers, the word count and cached end words,
// drives the ring memory and builds one result per request.
// ----------------------------------------------------------------------------
module cdq_ctrl import cdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic signed [WORD_W-1:0] in_push_value,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output cdq_result_t              rsp,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic signed [WORD_W-1:0] mem_wdata,
  output logic                     mem_re,
  output logic [AW-1:0]            mem_raddr,
  input  logic signed [WORD_W-1:0] mem_rdata
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  cdq_state_t state, state_next;

  logic [AW-1:0]            head, head_next;
  logic [AW-1:0]            tail, tail_next;
  logic [AW-1:0]            held, held_next;
  logic signed [WORD_W-1:0] front_word, front_word_next;
  logic signed [WORD_W-1:0] back_word, back_word_next;

  logic signed [WORD_W-1:0] pend_popped, pend_popped_next;
  logic                     pend_pvalid, pend_pvalid_next;
  logic                     pend_ovf, pend_ovf_next;
  logic                     load_front, load_front_next;
  logic                     load_back, load_back_next;

  logic          accept, rsp_fire, full, empty;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec, tail_dec2;
  logic [AW+COUNT_W-1:0]    held_ext;
  logic signed [WORD_W-1:0] front_sel, back_sel;
  cdq_func_t                func;

  assign accept   = in_valid && in_ready;
  assign rsp_fire = rsp_valid && rsp_ready;
  assign full     = (held == LAST);
  assign empty    = (held == '0);
  assign func     = cdq_func_t'(in_func);

  assign head_inc  = (head == LAST) ? '0 : head + 1'b1;
  assign head_dec  = (head == '0) ? LAST : head - 1'b1;
  assign tail_inc  = (tail == LAST) ? '0 : tail + 1'b1;
  assign tail_dec  = (tail == '0) ? LAST : tail - 1'b1;
  assign tail_dec2 = (tail_dec == '0) ? LAST : tail_dec - 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      CDQ_IDLE: begin
        if (accept) begin
          state_next = CDQ_RESP;
        end
      end
      CDQ_RESP: begin
        if (rsp_fire) begin
          state_next = CDQ_IDLE;
        end
      end
      default: state_next = CDQ_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = 1'b0;
    rsp_valid = 1'b0;
    case (state)
      CDQ_IDLE: in_ready  = 1'b1;
      CDQ_RESP: rsp_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        rsp_valid = 1'b0;
      end
    endcase
  end

  // Request decode. A pop that leaves words behind fetches the new end word
  // from the ring; pushes write the ring and update the cached ends directly.
  always_comb begin
    head_next        = head;
    tail_next        = tail;
    held_next        = held;
    front_word_next  = front_word;
    back_word_next   = back_word;
    pend_popped_next = pend_popped;
    pend_pvalid_next = pend_pvalid;
    pend_ovf_next    = pend_ovf;
    load_front_next  = load_front;
    load_back_next   = load_back;
    mem_we           = 1'b0;
    mem_waddr        = tail;
    mem_wdata        = in_push_value;
    mem_re           = 1'b0;
    mem_raddr        = head_inc;

    if (accept) begin
      pend_popped_next = '0;
      pend_pvalid_next = 1'b0;
      pend_ovf_next    = 1'b0;
      load_front_next  = 1'b0;
      load_back_next   = 1'b0;
      case (func)
        FN_PUSH_FRONT: begin
          if (full) begin
            pend_ovf_next = 1'b1;
          end else begin
            head_next       = head_dec;
            held_next       = held + 1'b1;
            mem_we          = 1'b1;
            mem_waddr       = head_dec;
            front_word_next = in_push_value;
            if (empty) begin
              back_word_next = in_push_value;
            end
          end
        end
        FN_PUSH_BACK: begin
          if (full) begin
            pend_ovf_next = 1'b1;
          end else begin
            tail_next      = tail_inc;
            held_next      = held + 1'b1;
            mem_we         = 1'b1;
            mem_waddr      = tail;
            back_word_next = in_push_value;
            if (empty) begin
              front_word_next = in_push_value;
            end
          end
        end
        FN_POP_FRONT: begin
          if (!empty) begin
            pend_popped_next = front_word;
            pend_pvalid_next = 1'b1;
            head_next        = head_inc;
            held_next        = held - 1'b1;
            if (held != AW'(1)) begin
              mem_re          = 1'b1;
              mem_raddr       = head_inc;
              load_front_next = 1'b1;
            end
          end
        end
        FN_POP_BACK: begin
          if (!empty) begin
            pend_popped_next = back_word;
            pend_pvalid_next = 1'b1;
            tail_next        = tail_dec;
            held_next        = held - 1'b1;
            if (held != AW'(1)) begin
              mem_re         = 1'b1;
              mem_raddr      = tail_dec2;
              load_back_next = 1'b1;
            end
          end
        end
        default: begin
          pend_popped_next = '0;
        end
      endcase
    end

    if (rsp_fire) begin
      front_word_next = front_sel;
      back_word_next  = back_sel;
    end
  end

  assign front_sel = load_front ? mem_rdata : front_word;
  assign back_sel  = load_back ? mem_rdata : back_word;
  assign held_ext  = {{COUNT_W{1'b0}}, held};

  always_comb begin
    rsp.popped_value = pend_popped;
    rsp.popped_valid = pend_pvalid;
    rsp.overflow     = pend_ovf;
    rsp.count        = held_ext[COUNT_W-1:0];
    rsp.is_empty     = empty;
    rsp.ends_valid   = !empty;
    rsp.front_value  = empty ? '0 : front_sel;
    rsp.back_value   = empty ? '0 : back_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CDQ_IDLE;
      head  <= '0;
      tail  <= '0;
      held  <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      held  <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    front_word  <= front_word_next;
    back_word   <= back_word_next;
    pend_popped <= pend_popped_next;
    pend_pvalid <= pend_pvalid_next;
    pend_ovf    <= pend_ovf_next;
    load_front  <= load_front_next;
    load_back   <= load_back_next;
  end

endmodule

>>> sv/circular_deque_unit.sv
// ----------------------------------------------------------------------------
// circular_deque_unit: double-ended queue of signed 32-bit words
// A ring memory addressed by head and tail pointers, with one result per
// request giving the popped word, overflow, size and both end words.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Width  Contents
//   s_axis    in    40     request: func, push_value
//   m_axis    out   112    result: popped word, flags, count, end words
//
// Each request has an accept cycle, where pointers move and the ring is
// written or read, and a response state, where the registered read data
// of the ring (the new front or back word after a pop) is merged into the
// result; the response state holds until the output register takes it.
// Reset clears the pointers and the count; the ring needs no clearing pass,
// because only occupied entries are ever read.
// A result waiting in the output register does not block the next request;
// only the one after that waits until the result is taken.
//
module circular_deque_unit import cdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [2:0] func, [34:3] push_value, [39:35] zero
  input  logic [39:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] popped_value, [32] popped_valid, [33] overflow, [43:34] count,
  // [44] is_empty, [76:45] front_value, [108:77] back_value,
  // [109] ends_valid, [111:110] zero
  output logic [111:0] m_tdata
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                     rsp_valid, rsp_ready;
  cdq_result_t              rsp, out_res;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic signed [WORD_W-1:0] mem_wdata, mem_rdata;

  cdq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_func       (s_tdata[2:0]),
    .in_push_value (s_tdata[34:3]),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  cdq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: takes a new result when empty or being drained.
  assign rsp_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      out_res <= rsp;
    end
  end

  assign m_tdata = {2'b00, out_res};

endmodule

>>> sv/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker: port-level checks of the deque
// Watches the stream ports of circular_deque_unit over time.
// ----------------------------------------------------------------------------
`include "circular_deque_unit_defines.svh"

module cdq_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata
);

  // A stalled result holds.
  `CDQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Requests are handled one at a time.
  `CDQ_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

  // End words are valid exactly when the deque holds words.
  `CDQ_ASSERT_NOW(a_ends_vs_empty, m_tvalid, m_tdata[109] != m_tdata[44])

  // A request cannot both pop a word and be rejected as a full push.
  `CDQ_ASSERT_NOW(a_pop_or_ovf, m_tvalid, !(m_tdata[32] && m_tdata[33]))

  // An empty deque reports zero end words.
  `CDQ_ASSERT_NOW(a_empty_zero, m_tvalid && m_tdata[44], m_tdata[108:45] == 64'd0)

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
